/* rtl/core/trr_pkg.sv */
// trr_pkg: shared types, sizes and request codes for the trace record ring.
// No dependencies; imported by every module of the block but trr_ram.
`timescale 1ns / 1ps

package trr_pkg;

   // Ring geometry
   localparam int RING_SLOTS     = 64;
   localparam int RECORD_WORDS   = 8;
   localparam int PAYLOAD_INPUTS = 6;
   localparam int SLOT_W         = $clog2(RING_SLOTS);
   localparam int WORD_W         = $clog2(RECORD_WORDS);
   localparam int RING_DEPTH     = RING_SLOTS * RECORD_WORDS;
   localparam int ADDR_W         = $clog2(RING_DEPTH);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request codes
   localparam logic [2:0] OP_ARM    = 3'd0;
   localparam logic [2:0] OP_STAGE  = 3'd1;
   localparam logic [2:0] OP_LOG    = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_FREEZE = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] tag;
      logic [31:0] stage_bits;
      logic [2:0]  payload_count;
      logic [31:0] payload_0;
      logic [31:0] payload_1;
      logic [31:0] payload_2;
      logic [31:0] payload_3;
      logic [31:0] payload_4;
      logic [31:0] payload_5;
      logic [5:0]  read_slot;
      logic [2:0]  read_word;
   } trr_req_type;

   typedef struct packed {
      logic        accepted;
      logic [5:0]  slot_used;
      logic [31:0] seq_used;
      logic [31:0] arm_count;
      logic [31:0] stage_mask;
      logic [31:0] next_seq;
      logic [5:0]  write_index;
      logic        frozen_flag;
      logic [31:0] read_data;
   } trr_rsp_type;

   // Classified request as queued for the back end
   typedef struct packed {
      logic [2:0]                         op;
      logic [31:0]                        tag;
      logic [31:0]                        stage_bits;
      logic [PAYLOAD_INPUTS-1:0][31:0]    pay;      // words past the count already zero
      logic [SLOT_W-1:0]                  rd_slot;
      logic [WORD_W-1:0]                  rd_word;
      logic                               rd_ok;    // read address inside the ring
   } trr_cmd_type;

endpackage

/* rtl/core/trr_ram.sv */
// trr_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module trr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/trr_front.sv */
// trr_front: accepts requests, classifies them into commands and queues them.
// Depends on trr_pkg.
`timescale 1ns / 1ps

module trr_front import trr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  trr_req_type req_data,
   output logic        cmd_valid,
   output trr_cmd_type cmd_data,
   input  logic        cmd_pop
);

   trr_cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   trr_cmd_type             cmd_new;
   logic [PAYLOAD_INPUTS-1:0][31:0] pay_raw;
   logic [2:0]              cnt_sat;
   logic                    push;

   // Classify: saturate the count, zero unused payload, range check reads
   always_comb begin
      pay_raw = {req_data.payload_5, req_data.payload_4, req_data.payload_3,
                 req_data.payload_2, req_data.payload_1, req_data.payload_0};
      cnt_sat = (32'(req_data.payload_count) > PAYLOAD_INPUTS) ?
                3'(PAYLOAD_INPUTS) : req_data.payload_count;
      cmd_new.op         = req_data.req_type;
      cmd_new.tag        = req_data.tag;
      cmd_new.stage_bits = req_data.stage_bits;
      for (int i = 0; i < PAYLOAD_INPUTS; i++) begin
         cmd_new.pay[i] = (i < 32'(cnt_sat)) ? pay_raw[i] : 32'd0;
      end
      cmd_new.rd_slot = SLOT_W'(req_data.read_slot);
      cmd_new.rd_word = WORD_W'(req_data.read_word);
      cmd_new.rd_ok   = (32'(req_data.read_slot) < RING_SLOTS) &&
                        (32'(req_data.read_word) < RECORD_WORDS);
   end

   // Queue control
   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

/* rtl/core/trr_back.sv */
// trr_back: executes queued commands: header state, ring writes and reads,
// result register. Depends on trr_pkg and trr_ram.
`timescale 1ns / 1ps

module trr_back import trr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  trr_cmd_type cmd_data,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output trr_rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WRITE = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;
   localparam logic [1:0] ST_RDATA = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [WORD_W-1:0]               wcnt_ff, wcnt_in;
   logic                            hv_ff, hv_in;
   logic [31:0]                     arms_ff, arms_in;
   logic [31:0]                     crumbs_ff, crumbs_in;
   logic [31:0]                     seq_ff, seq_in;
   logic [SLOT_W-1:0]               cursor_ff, cursor_in;
   logic                            frozen_ff, frozen_in;
   logic [RING_SLOTS-1:0]           row_valid_ff, row_valid_in;
   logic [31:0]                     lseq_ff, lseq_in;
   logic [SLOT_W-1:0]               lslot_ff, lslot_in;
   logic [31:0]                     ltag_ff, ltag_in;
   logic [PAYLOAD_INPUTS-1:0][31:0] lpay_ff, lpay_in;
   logic                            rd_keep_ff, rd_keep_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   trr_rsp_type                     rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              emit;
   logic              emit_acc;
   logic [31:0]       emit_rdata;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [31:0]       ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [31:0]       ram_rd_data;

   trr_ram #(
      .WIDTH (32),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Record word being written this cycle
   always_comb begin
      ram_wr_data = 32'd0;
      if (wcnt_ff == WORD_W'(0)) begin
         ram_wr_data = lseq_ff;
      end else if (wcnt_ff == WORD_W'(1)) begin
         ram_wr_data = ltag_ff;
      end else begin
         for (int i = 0; i < PAYLOAD_INPUTS; i++) begin
            if (32'(wcnt_ff) == i + 2) begin
               ram_wr_data = lpay_ff[i];
            end
         end
      end
   end

   assign ram_wr_addr = ADDR_W'(lslot_ff) * ADDR_W'(RECORD_WORDS) + ADDR_W'(wcnt_ff);
   assign ram_rd_addr = ADDR_W'(cmd_data.rd_slot) * ADDR_W'(RECORD_WORDS) +
                        ADDR_W'(cmd_data.rd_word);

   // Command sequencer
   always_comb begin
      state_in     = state_ff;
      wcnt_in      = wcnt_ff;
      hv_in        = hv_ff;
      arms_in      = arms_ff;
      crumbs_in    = crumbs_ff;
      seq_in       = seq_ff;
      cursor_in    = cursor_ff;
      frozen_in    = frozen_ff;
      row_valid_in = row_valid_ff;
      lseq_in      = lseq_ff;
      lslot_in     = lslot_ff;
      ltag_in      = ltag_ff;
      lpay_in      = lpay_ff;
      rd_keep_in   = rd_keep_ff;
      cmd_pop      = 1'b0;
      emit         = 1'b0;
      emit_acc     = 1'b0;
      emit_rdata   = 32'd0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  OP_ARM: begin
                     emit = 1'b1;
                     if (hv_ff) begin
                        arms_in = arms_ff + 32'd1;
                     end else begin
                        // cold arm: fresh header, empty ring
                        hv_in        = 1'b1;
                        arms_in      = 32'd1;
                        crumbs_in    = 32'd0;
                        seq_in       = 32'd0;
                        cursor_in    = '0;
                        frozen_in    = 1'b0;
                        row_valid_in = '0;
                     end
                  end
                  OP_STAGE: begin
                     emit      = 1'b1;
                     crumbs_in = crumbs_ff | cmd_data.stage_bits;
                  end
                  OP_LOG: begin
                     if (frozen_ff) begin
                        emit = 1'b1;
                     end else begin
                        lseq_in   = seq_ff;
                        lslot_in  = cursor_ff;
                        ltag_in   = cmd_data.tag;
                        lpay_in   = cmd_data.pay;
                        seq_in    = seq_ff + 32'd1;
                        cursor_in = (cursor_ff == SLOT_W'(RING_SLOTS - 1)) ?
                                    '0 : cursor_ff + 1'b1;
                        row_valid_in[cursor_ff] = 1'b1;
                        wcnt_in   = '0;
                        state_in  = ST_WRITE;
                     end
                  end
                  OP_CLEAR: begin
                     emit         = 1'b1;
                     seq_in       = 32'd0;
                     cursor_in    = '0;
                     frozen_in    = 1'b0;
                     row_valid_in = '0;
                  end
                  OP_FREEZE: begin
                     emit      = 1'b1;
                     frozen_in = 1'b1;
                  end
                  OP_READ: begin
                     ram_rd_en  = 1'b1;
                     rd_keep_in = cmd_data.rd_ok && row_valid_ff[cmd_data.rd_slot];
                     state_in   = ST_RDATA;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            wcnt_in   = wcnt_ff + 1'b1;
            if (wcnt_ff == WORD_W'(RECORD_WORDS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               emit_acc = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RDATA: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_rdata = rd_keep_ff ? ram_rd_data : 32'd0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result assembly from the post-step header
   always_comb begin
      rsp_data_in.accepted    = emit_acc;
      rsp_data_in.slot_used   = emit_acc ? 6'(lslot_ff) : 6'd0;
      rsp_data_in.seq_used    = emit_acc ? lseq_ff : 32'd0;
      rsp_data_in.arm_count   = arms_in;
      rsp_data_in.stage_mask  = crumbs_in;
      rsp_data_in.next_seq    = seq_in;
      rsp_data_in.write_index = 6'(cursor_in);
      rsp_data_in.frozen_flag = frozen_in;
      rsp_data_in.read_data   = emit_rdata;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and header registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wcnt_ff      <= '0;
         hv_ff        <= 1'b0;
         arms_ff      <= 32'd0;
         crumbs_ff    <= 32'd0;
         seq_ff       <= 32'd0;
         cursor_ff    <= '0;
         frozen_ff    <= 1'b0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         hv_ff        <= hv_in;
         arms_ff      <= arms_in;
         crumbs_ff    <= crumbs_in;
         seq_ff       <= seq_in;
         cursor_ff    <= cursor_in;
         frozen_ff    <= frozen_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lseq_ff    <= lseq_in;
      lslot_ff   <= lslot_in;
      ltag_ff    <= ltag_in;
      lpay_ff    <= lpay_in;
      rd_keep_ff <= rd_keep_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/trace_record_ring.sv */
// trace_record_ring: diagnostic trace ring, front classifier + command queue + back executor.
// Path: front command queue, back end, result register; reads add the registered ring RAM read.
// Throughput: one item a cycle for header requests while results are not stalled; a log
// holds the back end for its record writes (one ring word a cycle), a read for its RAM read.
// Reset: synchronous active high; clears header, queue, row valid bits and result valid.
// Ring rows not written since the last cold arm or clear read as zero; no clearing pass.
`timescale 1ns / 1ps

module trace_record_ring import trr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  trr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output trr_rsp_type rsp_data
);

   logic        cmd_valid;
   logic        cmd_pop;
   trr_cmd_type cmd_data;

   trr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   trr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   // A written record advances the sequence by one and implies not frozen
   a_log_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.accepted) |->
         (rsp_data.next_seq == rsp_data.seq_used + 32'd1) && !rsp_data.frozen_flag)
      else $error("log result inconsistent with header");

   // Non-log results carry no slot or sequence
   a_no_log_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.accepted) |->
         (rsp_data.slot_used == 6'd0) && (rsp_data.seq_used == 32'd0))
      else $error("slot or sequence reported without a written record");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
